@@ rtl/bbge_pkg.sv @@
// Shared types and constants for the Brian's Brain grid engine.
`default_nettype none

package bbge_pkg;

    // Fixed field widths of the item channels.
    localparam int CMD_W   = 2;
    localparam int COORD_W = 6;
    localparam int CELL_W  = 2;
    localparam int POP_W   = 13;
    localparam int GEN_W   = 32;

    // Command codes; the unused code behaves as a read.
    localparam logic [CMD_W-1:0] CMD_CYCLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Cell state codes.
    localparam logic [CELL_W-1:0] ST_OFF   = 2'd0;
    localparam logic [CELL_W-1:0] ST_ON    = 2'd1;
    localparam logic [CELL_W-1:0] ST_DYING = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_CELL,
        FSM_STEP,
        FSM_DRAIN,
        FSM_OUT
    } fsm_t;

    // Tag that travels with each read of the generation sweep.
    typedef struct packed {
        logic valid;
        logic compute;
        logic last;
    } win_ctl_t;

    // Result of the neighborhood evaluation for one cell.
    typedef struct packed {
        logic              we;
        logic              done;
        logic              born;
        logic              died;
        logic [CELL_W-1:0] state;
    } win_res_t;

endpackage

`default_nettype wire

@@ rtl/brians_brain_grid_engine_core.sv @@
// Top level of the Brian's Brain grid engine: control, grid memories and result register.
//
// Usage: items enter on the s_ channel (command, col, row) and each item yields
// exactly one result on the m_ channel (cell_state, population, generation).
// Both channels are valid/ready; an item moves when valid and ready are high.
// The grid lives in two GRID_SIZE*GRID_SIZE by 2-bit memories used as ping-pong
// banks: one holds the current generation, the other receives the next one.
// Cycle and read commands issue the memory read in the accepting cycle; the FSM_CELL
// state then modifies and writes back the cell, and FSM_OUT loads the result register.
// A step command sweeps the current bank one cell per cycle, reading rows
// GRID_SIZE-1, 0 .. GRID_SIZE-1, 0, 1 to feed a four-row window; the single read
// port of the current bank sets that pace.
// One item is worked on at a time; s_ready rises again once the result has been
// placed in the result register, so the next item is taken while that result
// still waits for m_ready. A stalled receiver holds the next finished result
// until the register frees up.
// After reset the block clears the current bank, one entry per cycle, over all
// GRID_SIZE*GRID_SIZE entries (4096 at GRID_SIZE = 64) before s_ready rises.
`default_nettype none

module brians_brain_grid_engine_core
    import bbge_pkg::*;
#(
    parameter int GRID_SIZE = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [CMD_W-1:0]   s_command,
    input  wire logic [COORD_W-1:0] s_col,
    input  wire logic [COORD_W-1:0] s_row,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [CELL_W-1:0]       m_cell_state,
    output logic [POP_W-1:0]        m_population,
    output logic [GEN_W-1:0]        m_generation
);

    localparam int IDX_W     = $clog2(GRID_SIZE);
    localparam int CELLS     = GRID_SIZE * GRID_SIZE;
    localparam int AW        = $clog2(CELLS);
    localparam int SWEEP     = (GRID_SIZE + 3) * GRID_SIZE;
    localparam int CW        = $clog2(SWEEP);
    localparam int CMP_START = 3 * GRID_SIZE;
    localparam int COORDS    = 1 << COORD_W;

    fsm_t              state_reg, state_next;
    logic              cur_sel_reg, cur_sel_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [AW-1:0]     rd_addr_reg, rd_addr_next;
    logic [CW-1:0]     rd_cnt_reg, rd_cnt_next;
    logic [IDX_W-1:0]  rd_col_reg, rd_col_next;
    logic [AW-1:0]     wr_addr_reg, wr_addr_next;
    logic [POP_W-1:0]  live_reg, live_next;
    logic [GEN_W-1:0]  gen_reg, gen_next;
    logic [CELL_W-1:0] res_cell_reg, res_cell_next;
    logic              m_valid_reg, m_valid_next;
    logic [CELL_W-1:0] m_cell_reg, m_cell_next;
    logic [POP_W-1:0]  m_pop_reg, m_pop_next;
    logic [GEN_W-1:0]  m_gen_reg, m_gen_next;

    logic [IDX_W-1:0]  wrap_lut [COORDS];
    logic [IDX_W-1:0]  col_w, row_w;
    logic [AW-1:0]     in_addr;

    logic [AW-1:0]     raddr;
    logic              cur_we, oth_we;
    logic [AW-1:0]     cur_waddr;
    logic [CELL_W-1:0] cur_wdata;
    logic              a_we, b_we;
    logic [AW-1:0]     a_waddr, b_waddr;
    logic [CELL_W-1:0] a_wdata, b_wdata;
    logic [CELL_W-1:0] a_rdata, b_rdata, rd_data;
    logic [CELL_W-1:0] cycled;

    win_ctl_t          win_ctl;
    win_res_t          win_res;

    // Coordinates reduce modulo the grid size through a constant table.
    for (genvar k = 0; k < COORDS; k++) begin : g_wrap
        assign wrap_lut[k] = IDX_W'(k % GRID_SIZE);
    end

    assign col_w   = wrap_lut[s_col];
    assign row_w   = wrap_lut[s_row];
    assign in_addr = AW'(row_w) * AW'(GRID_SIZE) + AW'(col_w);

    // Bank steering: the current bank takes clears and cycle writes,
    // the other bank takes the generation being built.
    assign a_we    = cur_sel_reg ? oth_we : cur_we;
    assign b_we    = cur_sel_reg ? cur_we : oth_we;
    assign a_waddr = cur_sel_reg ? wr_addr_reg : cur_waddr;
    assign b_waddr = cur_sel_reg ? cur_waddr : wr_addr_reg;
    assign a_wdata = cur_sel_reg ? win_res.state : cur_wdata;
    assign b_wdata = cur_sel_reg ? cur_wdata : win_res.state;
    assign rd_data = cur_sel_reg ? b_rdata : a_rdata;

    bbge_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELLS)
    ) u_bank_a (
        .aclk (aclk),
        .we   (a_we),
        .waddr(a_waddr),
        .wdata(a_wdata),
        .raddr(raddr),
        .rdata(a_rdata)
    );

    bbge_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELLS)
    ) u_bank_b (
        .aclk (aclk),
        .we   (b_we),
        .waddr(b_waddr),
        .wdata(b_wdata),
        .raddr(raddr),
        .rdata(b_rdata)
    );

    // Tag for each sweep read: evaluation starts once three rows are buffered.
    always_comb begin
        win_ctl.valid   = (state_reg == FSM_STEP);
        win_ctl.compute = (rd_cnt_reg >= CW'(CMP_START));
        win_ctl.last    = (rd_cnt_reg == CW'(SWEEP - 1));
    end

    bbge_window #(
        .GRID_SIZE(GRID_SIZE)
    ) u_window (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctl_in (win_ctl),
        .col_in (rd_col_reg),
        .rd_data(rd_data),
        .res    (win_res)
    );

    // Manual cycling of one cell.
    always_comb begin
        case (rd_data)
            ST_ON:    cycled = ST_DYING;
            ST_DYING: cycled = ST_OFF;
            default:  cycled = ST_ON;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_CLEAR;
            cur_sel_reg <= 1'b0;
            rd_addr_reg <= '0;
            live_reg    <= '0;
            gen_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_sel_reg <= cur_sel_next;
            rd_addr_reg <= rd_addr_next;
            live_reg    <= live_next;
            gen_reg     <= gen_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        addr_reg     <= addr_next;
        rd_cnt_reg   <= rd_cnt_next;
        rd_col_reg   <= rd_col_next;
        wr_addr_reg  <= wr_addr_next;
        res_cell_reg <= res_cell_next;
        m_cell_reg   <= m_cell_next;
        m_pop_reg    <= m_pop_next;
        m_gen_reg    <= m_gen_next;
    end

    // Next state and datapath control.
    always_comb begin
        state_next    = state_reg;
        cur_sel_next  = cur_sel_reg;
        cmd_next      = cmd_reg;
        addr_next     = addr_reg;
        rd_addr_next  = rd_addr_reg;
        rd_cnt_next   = rd_cnt_reg;
        rd_col_next   = rd_col_reg;
        wr_addr_next  = wr_addr_reg;
        live_next     = live_reg;
        gen_next      = gen_reg;
        res_cell_next = res_cell_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_cell_next   = m_cell_reg;
        m_pop_next    = m_pop_reg;
        m_gen_next    = m_gen_reg;
        s_ready       = 1'b0;
        raddr         = rd_addr_reg;
        cur_we        = 1'b0;
        cur_waddr     = addr_reg;
        cur_wdata     = ST_OFF;
        oth_we        = 1'b0;

        unique case (state_reg)
            FSM_CLEAR: begin
                cur_we    = 1'b1;
                cur_waddr = rd_addr_reg;
                if (rd_addr_reg == AW'(CELLS - 1)) begin
                    rd_addr_next = '0;
                    state_next   = FSM_IDLE;
                end else begin
                    rd_addr_next = rd_addr_reg + 1'b1;
                end
            end
            FSM_IDLE: begin
                s_ready = 1'b1;
                raddr   = in_addr;
                if (s_valid) begin
                    cmd_next  = s_command;
                    addr_next = in_addr;
                    if (s_command == CMD_STEP) begin
                        rd_addr_next = AW'(CELLS - GRID_SIZE);
                        rd_cnt_next  = '0;
                        rd_col_next  = '0;
                        wr_addr_next = '0;
                        state_next   = FSM_STEP;
                    end else begin
                        state_next = FSM_CELL;
                    end
                end
            end
            FSM_CELL: begin
                // Read data of the addressed cell is valid here.
                if (cmd_reg == CMD_CYCLE) begin
                    cur_we        = 1'b1;
                    cur_wdata     = cycled;
                    res_cell_next = cycled;
                    if (rd_data == ST_DYING) begin
                        live_next = live_reg - 1'b1;
                    end else if (rd_data != ST_ON) begin
                        live_next = live_reg + 1'b1;
                    end
                end else begin
                    res_cell_next = rd_data;
                end
                state_next = FSM_OUT;
            end
            FSM_STEP: begin
                // Stream the current bank in order, wrapping at the last entry.
                if (rd_addr_reg == AW'(CELLS - 1)) begin
                    rd_addr_next = '0;
                end else begin
                    rd_addr_next = rd_addr_reg + 1'b1;
                end
                if (rd_col_reg == IDX_W'(GRID_SIZE - 1)) begin
                    rd_col_next = '0;
                end else begin
                    rd_col_next = rd_col_reg + 1'b1;
                end
                rd_cnt_next = rd_cnt_reg + 1'b1;
                if (rd_cnt_reg == CW'(SWEEP - 1)) begin
                    state_next = FSM_DRAIN;
                end
            end
            FSM_DRAIN: begin
                // The last evaluated cell swaps the banks.
                if (win_res.done) begin
                    cur_sel_next  = !cur_sel_reg;
                    gen_next      = gen_reg + 1'b1;
                    res_cell_next = ST_OFF;
                    state_next    = FSM_OUT;
                end
            end
            FSM_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_cell_next  = res_cell_reg;
                    m_pop_next   = live_reg;
                    m_gen_next   = gen_reg;
                    state_next   = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase

        // Cells of the next generation go to the other bank.
        if (win_res.we) begin
            oth_we       = 1'b1;
            wr_addr_next = wr_addr_reg + 1'b1;
            if (win_res.born) begin
                live_next = live_reg + 1'b1;
            end else if (win_res.died) begin
                live_next = live_reg - 1'b1;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cell_state = m_cell_reg;
    assign m_population = m_pop_reg;
    assign m_generation = m_gen_reg;

endmodule

`default_nettype wire

@@ rtl/bbge_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module bbge_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/bbge_window.sv @@
// Row-buffer window over the cell stream and the Brian's Brain update rule.
`default_nettype none

module bbge_window
    import bbge_pkg::*;
#(
    parameter int GRID_SIZE = 64,
    localparam int IDX_W = $clog2(GRID_SIZE)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire win_ctl_t          ctl_in,
    input  wire logic [IDX_W-1:0]  col_in,
    input  wire logic [CELL_W-1:0] rd_data,
    output win_res_t               res
);

    // The line holds the last four rows of the stream; index 0 is the newest cell.
    localparam int LINE = 4 * GRID_SIZE;
    localparam int G    = GRID_SIZE;

    win_ctl_t          s1_ctl_reg, s2_ctl_reg;
    logic [IDX_W-1:0]  s1_col_reg, s2_col_reg;
    logic [CELL_W-1:0] line_reg [LINE];

    logic              first_col, last_col;
    logic [7:0]        nb_on;
    logic [3:0]        n_on;
    logic [CELL_W-1:0] center;
    logic              born;

    // Tag pipeline: stage one waits for the memory, stage two evaluates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
        end else begin
            s1_ctl_reg <= ctl_in;
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_col_reg <= col_in;
        s2_col_reg <= s1_col_reg;
    end

    // Shift each arriving cell into the row buffers.
    always_ff @(posedge aclk) begin
        if (s1_ctl_reg.valid) begin
            line_reg[0] <= rd_data;
            for (int k = 1; k < LINE; k++) begin
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    // The evaluated cell sits at the middle of the line, two rows behind the newest cell.
    // Edge columns take their wrapped neighbors from the adjacent tap.
    assign first_col = (s2_col_reg == '0);
    assign last_col  = (s2_col_reg == IDX_W'(G - 1));
    assign center    = line_reg[2*G];

    always_comb begin
        nb_on[0] = first_col ? (line_reg[1]     == ST_ON) : (line_reg[G+1]   == ST_ON);
        nb_on[1] = (line_reg[G] == ST_ON);
        nb_on[2] = last_col  ? (line_reg[2*G-1] == ST_ON) : (line_reg[G-1]   == ST_ON);
        nb_on[3] = first_col ? (line_reg[G+1]   == ST_ON) : (line_reg[2*G+1] == ST_ON);
        nb_on[4] = last_col  ? (line_reg[3*G-1] == ST_ON) : (line_reg[2*G-1] == ST_ON);
        nb_on[5] = first_col ? (line_reg[2*G+1] == ST_ON) : (line_reg[3*G+1] == ST_ON);
        nb_on[6] = (line_reg[3*G] == ST_ON);
        nb_on[7] = last_col  ? (line_reg[4*G-1] == ST_ON) : (line_reg[3*G-1] == ST_ON);
    end

    assign n_on = 4'($countones(nb_on));
    assign born = (center != ST_ON) && (center != ST_DYING) && (n_on == 4'd2);

    // Next state of the center cell and its effect on the population.
    always_comb begin
        res.we   = s2_ctl_reg.valid && s2_ctl_reg.compute;
        res.done = s2_ctl_reg.valid && s2_ctl_reg.last;
        res.born = res.we && born;
        res.died = res.we && (center == ST_DYING);
        case (center)
            ST_ON:    res.state = ST_DYING;
            ST_DYING: res.state = ST_OFF;
            default:  res.state = born ? ST_ON : ST_OFF;
        endcase
    end

endmodule

`default_nettype wire

@@ dv/bbge_checker.sv @@
// Checker for the Brian's Brain grid engine: tracks the grid and compares every result item.
`default_nettype none

module bbge_checker
    import bbge_pkg::*;
#(
    parameter int GRID_SIZE = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic [CMD_W-1:0]   s_command,
    input  wire logic [COORD_W-1:0] s_col,
    input  wire logic [COORD_W-1:0] s_row,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic [CELL_W-1:0]  m_cell_state,
    input  wire logic [POP_W-1:0]   m_population,
    input  wire logic [GEN_W-1:0]   m_generation,
    output int                      pending,
    output int                      failures
);

    localparam int CELLS = GRID_SIZE * GRID_SIZE;
    // An off cell is born when exactly this many neighbors are on.
    localparam int BIRTH_COUNT = 2;

    typedef struct packed {
        logic [CELL_W-1:0] cell_st;
        logic [POP_W-1:0]  pop;
        logic [GEN_W-1:0]  gen;
    } brain_result_t;

    // Shadow copy of the grid and the counters.
    logic [CELL_W-1:0] board [CELLS];
    logic [CELL_W-1:0] scratch [CELLS];
    int unsigned       live_cells;
    logic [GEN_W-1:0]  gen_count;
    brain_result_t     expected_q [$];

    // Prints one line for a failure and counts it.
    task automatic report_failure(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        failures++;
    endtask

    // Counts the on cells among the eight wrapped neighbors of a cell.
    function automatic int on_around(input int c, input int r);
        int n;
        int cc;
        int rr;
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                if (dr != 0 || dc != 0) begin
                    cc = (c + dc + GRID_SIZE) % GRID_SIZE;
                    rr = (r + dr + GRID_SIZE) % GRID_SIZE;
                    if (board[rr * GRID_SIZE + cc] == ST_ON) n++;
                end
            end
        end
        return n;
    endfunction

    // Computes one generation over the whole grid from the old grid only.
    function automatic void advance_generation();
        int idx;
        gen_count = gen_count + 1'b1;
        for (int r = 0; r < GRID_SIZE; r++) begin
            for (int c = 0; c < GRID_SIZE; c++) begin
                idx = r * GRID_SIZE + c;
                case (board[idx])
                    ST_ON: begin
                        scratch[idx] = ST_DYING;
                    end
                    ST_DYING: begin
                        scratch[idx] = ST_OFF;
                        live_cells--;
                    end
                    default: begin
                        if (on_around(c, r) == BIRTH_COUNT) begin
                            scratch[idx] = ST_ON;
                            live_cells++;
                        end else begin
                            scratch[idx] = ST_OFF;
                        end
                    end
                endcase
            end
        end
        board = scratch;
    endfunction

    // Applies one input item to the shadow grid and returns the result it should give.
    function automatic brain_result_t predict_item(
        input logic [CMD_W-1:0]   cmd,
        input logic [COORD_W-1:0] col,
        input logic [COORD_W-1:0] row
    );
        brain_result_t res;
        int idx;
        idx = (int'(row) % GRID_SIZE) * GRID_SIZE + (int'(col) % GRID_SIZE);
        case (cmd)
            CMD_STEP: begin
                advance_generation();
                res.cell_st = ST_OFF;
            end
            CMD_CYCLE: begin
                case (board[idx])
                    ST_ON: begin
                        board[idx] = ST_DYING;
                    end
                    ST_DYING: begin
                        board[idx] = ST_OFF;
                        live_cells--;
                    end
                    default: begin
                        board[idx] = ST_ON;
                        live_cells++;
                    end
                endcase
                res.cell_st = board[idx];
            end
            default: begin
                // Read, and the spare code, which behaves as a read.
                res.cell_st = board[idx];
            end
        endcase
        res.pop = live_cells[POP_W-1:0];
        res.gen = gen_count;
        return res;
    endfunction

    // Results are checked before the item accepted at the same edge is predicted.
    always @(posedge aclk) begin
        brain_result_t want;
        if (!aresetn) begin
            foreach (board[i]) begin
                board[i]   = ST_OFF;
                scratch[i] = ST_OFF;
            end
            live_cells = 0;
            gen_count  = '0;
            expected_q.delete();
            failures   = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_failure("result item arrived with nothing outstanding");
                end else begin
                    want = expected_q.pop_front();
                    if (m_cell_state !== want.cell_st)
                        report_failure($sformatf("cell_state got %0d, expected %0d",
                                                 m_cell_state, want.cell_st));
                    if (m_population !== want.pop)
                        report_failure($sformatf("population got %0d, expected %0d",
                                                 m_population, want.pop));
                    if (m_generation !== want.gen)
                        report_failure($sformatf("generation got %0d, expected %0d",
                                                 m_generation, want.gen));
                end
            end
            if (s_valid && s_ready)
                expected_q.insert(expected_q.size(), predict_item(s_command, s_col, s_row));
        end
        pending = expected_q.size();
    end

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Testbench top for the Brian's Brain grid engine: clock, reset, stimulus and verdict.
`default_nettype none

module tb_top
    import bbge_pkg::*;
;

    localparam int GRID_SIZE   = 64;
    // Clearing pass plus up to one full sweep per item, with wide margin.
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int RANDOM_ITEMS = 115;
    // The unused command code, which the block treats as a read.
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam logic [COORD_W-1:0] EDGE_HI = COORD_W'(GRID_SIZE - 1);

    typedef enum int {RX_OPEN, RX_CHOPPY, RX_CHOKED} rx_mode_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [CMD_W-1:0]   s_command = CMD_READ;
    logic [COORD_W-1:0] s_col     = '0;
    logic [COORD_W-1:0] s_row     = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic [CELL_W-1:0]  m_cell_state;
    logic [POP_W-1:0]   m_population;
    logic [GEN_W-1:0]   m_generation;

    int pending;
    int failures;
    int cycle_count = 0;
    int burst_left  = 0;
    int n_cycle     = 0;
    int n_step      = 0;
    int n_read      = 0;
    int n_spare     = 0;
    int n_drain     = 0;

    rx_mode_t rx_mode  = RX_OPEN;
    int       rx_left  = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    brians_brain_grid_engine_core #(
        .GRID_SIZE(GRID_SIZE)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_col(s_col),
        .s_row(s_row),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_cell_state(m_cell_state),
        .m_population(m_population),
        .m_generation(m_generation)
    );

    bbge_checker #(
        .GRID_SIZE(GRID_SIZE)
    ) checker_i (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_col(s_col),
        .s_row(s_row),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_cell_state(m_cell_state),
        .m_population(m_population),
        .m_generation(m_generation),
        .pending(pending),
        .failures(failures)
    );

    // Receiver back-pressure: open, choppy or mostly stalled stretches of random length.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_left = $urandom_range(10, 200);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_CHOPPY: m_ready <= 1'($urandom_range(0, 1));
            default:   m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Timeout watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding.",
                 cycle_count, pending);
        $display("FAIL brians_brain_grid_engine_core");
        $finish;
    end

    // Presents one item, with a random gap at the start of each burst, and waits for it.
    task automatic send_item(
        input logic [CMD_W-1:0]   cmd,
        input logic [COORD_W-1:0] c,
        input logic [COORD_W-1:0] r
    );
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 10);
            if (gap > 0) begin
                if (s_valid) s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30)
                                                     : $urandom_range(1, 6);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_col     <= c;
        s_row     <= r;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        burst_left--;
        case (cmd)
            CMD_CYCLE: n_cycle++;
            CMD_STEP:  n_step++;
            CMD_READ:  n_read++;
            default:   n_spare++;
        endcase
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain_results();
        if (s_valid) s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        burst_left = 0;
        n_drain++;
    endtask

    initial begin
        int rand_items;
        int n_seed;
        int n_gens;
        int n_noise;
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;

        rand_items = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: one cell through all three states, then a birth across both wrapped edges.
        send_item(CMD_READ, '0, '0);
        send_item(CMD_CYCLE, '0, '0);
        send_item(CMD_CYCLE, '0, '0);
        send_item(CMD_CYCLE, '0, '0);
        send_item(CMD_SPARE, EDGE_HI, EDGE_HI);
        send_item(CMD_CYCLE, EDGE_HI, EDGE_HI);
        send_item(CMD_CYCLE, COORD_W'(1), EDGE_HI);
        send_item(CMD_READ, EDGE_HI, '0);
        send_item(CMD_STEP, EDGE_HI, EDGE_HI);
        send_item(CMD_READ, '0, '0);
        send_item(CMD_SPARE, EDGE_HI, EDGE_HI);
        drain_results();
        send_item(CMD_STEP, '0, '0);
        send_item(CMD_READ, '0, '0);
        send_item(CMD_STEP, '0, EDGE_HI);
        send_item(CMD_READ, '0, '0);
        // An adjacent on pair stepped to births beside it, then one of the pair cycled from dying to off and stepped.
        send_item(CMD_CYCLE, COORD_W'(5), COORD_W'(5));
        send_item(CMD_CYCLE, COORD_W'(6), COORD_W'(5));
        send_item(CMD_STEP, EDGE_HI, '0);
        send_item(CMD_READ, COORD_W'(5), COORD_W'(4));
        send_item(CMD_READ, COORD_W'(6), COORD_W'(6));
        send_item(CMD_CYCLE, COORD_W'(6), COORD_W'(5));
        send_item(CMD_STEP, '0, '0);
        send_item(CMD_READ, COORD_W'(6), COORD_W'(5));

        // Random: seed a small cluster, step it a few times, probe it, add some noise.
        while (rand_items < RANDOM_ITEMS) begin
            ox = COORD_W'($urandom_range(0, GRID_SIZE - 1));
            oy = COORD_W'($urandom_range(0, GRID_SIZE - 1));
            if ($urandom_range(0, 2) == 0) ox = COORD_W'($urandom_range(60, 63));
            if ($urandom_range(0, 2) == 0) oy = COORD_W'($urandom_range(60, 63));

            n_seed = $urandom_range(3, 10);
            repeat (n_seed) begin
                send_item(CMD_CYCLE, ox + COORD_W'($urandom_range(0, 4)),
                          oy + COORD_W'($urandom_range(0, 4)));
                rand_items++;
            end

            n_gens = $urandom_range(1, 3);
            repeat (n_gens) begin
                send_item(CMD_STEP, COORD_W'($urandom), COORD_W'($urandom));
                rand_items++;
                repeat ($urandom_range(1, 3)) begin
                    send_item(($urandom_range(0, 3) == 0) ? CMD_SPARE : CMD_READ,
                              ox + COORD_W'($urandom_range(0, 5)) - 1'b1,
                              oy + COORD_W'($urandom_range(0, 5)) - 1'b1);
                    rand_items++;
                end
            end

            n_noise = $urandom_range(0, 3);
            repeat (n_noise) begin
                send_item(CMD_W'($urandom_range(0, 3)), COORD_W'($urandom),
                          COORD_W'($urandom));
                rand_items++;
            end

            if ($urandom_range(0, 3) == 0) drain_results();
        end

        drain_results();
        repeat (20) @(negedge aclk);

        $display("Sent %0d items: %0d cell cycles, %0d generation steps, %0d reads",
                 n_cycle + n_step + n_read + n_spare, n_cycle, n_step, n_read + n_spare);
        $display("(%0d on the spare code), with %0d full drains and %0d cycles in all.",
                 n_spare, n_drain, cycle_count);
        if (failures == 0) begin
            $display("PASS brians_brain_grid_engine_core");
        end else begin
            $display("%0d mismatches found.", failures);
            $display("FAIL brians_brain_grid_engine_core");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/bbge_pkg.sv
rtl/bbge_ram.sv
rtl/bbge_window.sv
rtl/brians_brain_grid_engine_core.sv
dv/bbge_checker.sv
dv/tb_top.sv
